FILE: design/mcmono_pkg.sv
// ----------------------------------------------------------------------------
// mcmono_pkg
// Shared widths, format codes, register indexes and control types for the
// multichannel to mono downmix.
// ----------------------------------------------------------------------------
package mcmono_pkg;

  localparam int MAX_CH_DEF = 8;   // default number of decode lanes
  localparam int NUM_SLOTS  = 8;   // channel words carried by one frame
  localparam int NUM_PAIRS  = NUM_SLOTS / 2;

  localparam int FMT_W      = 3;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam int LANE_W     = 32;  // Q5.26 float value or sign-extended PCM16
  localparam int PAIR_W     = LANE_W + 1;
  localparam int SUM_W      = LANE_W + 3;
  localparam int MAG_W      = 29;  // magnitude that reaches the divider
  localparam int Q_FRAC     = 26;
  localparam int RECIP_W    = 32;
  localparam int OUT_W      = 16;

  localparam logic [FMT_W-1:0] FMT_FLOAT = 3'd0;
  localparam logic [FMT_W-1:0] FMT_PCM16 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_PCM24 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_PCM32 = 3'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;

  localparam logic [FMT_W-1:0] FORMAT_RST = FMT_PCM16;
  localparam logic [CNT_W-1:0] COUNT_RST  = 4'd1;

  localparam logic [14:0]      PCM_SCALE  = 15'd32767;
  localparam logic [MAG_W-1:0] Q_ONE      = MAG_W'(1) << Q_FRAC;

  typedef struct packed {
    logic             active;
    logic [FMT_W-1:0] fmt;
  } mcmono_lane_ctrl_t;

  typedef struct packed {
    logic             float_mode;
    logic [CNT_W-1:0] div_n;
  } mcmono_div_ctrl_t;

  // floor(2^32 / n); a count of one bypasses the multiplier.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    unique case (n)
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/mcmono_lane.sv
// ----------------------------------------------------------------------------
// mcmono_lane
// Decodes one channel word into a signed 32-bit value: Q5.26 for float32,
// a 16-bit sample for the PCM formats. Inactive lanes give zero.
// ----------------------------------------------------------------------------
module mcmono_lane
  import mcmono_pkg::*;
(
  input  logic                     clk,
  input  logic                     load,
  input  mcmono_lane_ctrl_t        ctrl,
  input  logic [31:0]              word,
  output logic signed [LANE_W-1:0] value
);

  logic [7:0]               ex;
  logic [22:0]              man;
  logic [31:0]              sig;
  logic [3:0]               lsh;
  logic [7:0]               rsh;
  logic [31:0]              mag;
  logic signed [LANE_W-1:0] fq;
  logic signed [LANE_W-1:0] value_next;

  always_comb begin
    ex  = word[30:23];
    man = word[22:0];
    sig = {8'b0, 1'b1, man};
    lsh = 4'(ex - 8'd124);
    rsh = 8'd124 - ex;
    // Infinity and values too large saturate; NaN and subnormals give zero.
    if (ex == 8'hFF) begin
      mag = (man != '0) ? '0 : '1;
    end else if (ex == 8'd0) begin
      mag = '0;
    end else if (ex > 8'd132) begin
      mag = '1;
    end else if (ex >= 8'd124) begin
      mag = sig << lsh;
    end else if (rsh >= 8'd32) begin
      mag = '0;
    end else begin
      mag = sig >> rsh[4:0];
    end

    if (word[31]) begin
      fq = mag[31] ? 32'sh8000_0000 : -$signed(mag);
    end else begin
      fq = mag[31] ? 32'sh7FFF_FFFF : $signed(mag);
    end
  end

  always_comb begin
    value_next = '0;
    if (ctrl.active) begin
      unique case (ctrl.fmt)
        FMT_FLOAT: value_next = fq;
        FMT_PCM16: value_next = LANE_W'($signed(word[15:0]));
        FMT_PCM24: value_next = LANE_W'($signed(word[23:8]));
        FMT_PCM32: value_next = LANE_W'($signed(word[31:16]));
        default:   value_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= value_next;
    end
  end

endmodule

FILE: design/mcmono_merge.sv
// ----------------------------------------------------------------------------
// mcmono_merge
// Two-level registered adder tree that sums the lane values of one frame.
// ----------------------------------------------------------------------------
module mcmono_merge
  import mcmono_pkg::*;
(
  input  logic                     clk,
  input  logic [1:0]               load,
  input  logic signed [LANE_W-1:0] lane_val [NUM_SLOTS],
  output logic signed [SUM_W-1:0]  sum
);

  logic signed [PAIR_W-1:0] pair [NUM_PAIRS];
  logic signed [SUM_W-1:0]  sum_next;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      for (int i = 0; i < NUM_PAIRS; i++) begin
        pair[i] <= PAIR_W'(lane_val[2*i]) + PAIR_W'(lane_val[2*i+1]);
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < NUM_PAIRS; i++) begin
      sum_next = sum_next + SUM_W'(pair[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      sum <= sum_next;
    end
  end

endmodule

FILE: design/mcmono_scale.sv
// ----------------------------------------------------------------------------
// mcmono_scale
// Divides the frame sum by the channel count (truncating toward zero),
// clamps float means to +/-1.0 and scales them to 16-bit PCM.
// ----------------------------------------------------------------------------
module mcmono_scale
  import mcmono_pkg::*;
(
  input  logic                    clk,
  input  logic [3:0]              load,
  input  mcmono_div_ctrl_t        ctrl,
  input  logic signed [SUM_W-1:0] sum,
  output logic signed [OUT_W-1:0] mono_sample
);

  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int BACK_W  = MAG_W + CNT_W;
  localparam int SCALE_W = Q_FRAC + 1 + 15;

  // Stage 1: magnitude and clamp detection.
  logic [SUM_W-1:0]   mag_full;
  logic [SUM_W-1:0]   limit;
  logic               s1_neg, s1_big;
  logic [MAG_W-1:0]   s1_mag;

  // Stage 2: quotient estimate.
  logic [PROD_W-1:0]  prod;
  logic [MAG_W-1:0]   q0;
  logic               s2_neg, s2_big;
  logic [MAG_W-1:0]   s2_mag, s2_q0;

  // Stage 3: one-step correction.
  logic [BACK_W-1:0]  back;
  logic [BACK_W-1:0]  rem;
  logic [MAG_W-1:0]   q;
  logic               s3_neg;
  logic [MAG_W-1:0]   s3_q;

  // Stage 4: output scaling.
  logic [SCALE_W-1:0] scaled;
  logic [OUT_W:0]     mag_out;
  logic [OUT_W:0]     res;

  always_comb begin
    mag_full = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    limit    = SUM_W'({ctrl.div_n, {Q_FRAC{1'b0}}});
  end

  // A float mean at or beyond one is clamped, so only sums below
  // count * 2^26 need a real quotient.
  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_neg <= sum[SUM_W-1];
      s1_big <= ctrl.float_mode && (mag_full >= limit);
      s1_mag <= mag_full[MAG_W-1:0];
    end
  end

  always_comb begin
    prod = PROD_W'(s1_mag) * PROD_W'(recip(ctrl.div_n));
    q0   = (ctrl.div_n == CNT_W'(1)) ? s1_mag : prod[PROD_W-1:RECIP_W];
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_neg <= s1_neg;
      s2_big <= s1_big;
      s2_mag <= s1_mag;
      s2_q0  <= q0;
    end
  end

  // The reciprocal is rounded down, so the estimate is short by at most one.
  always_comb begin
    back = BACK_W'(s2_q0) * BACK_W'(ctrl.div_n);
    rem  = BACK_W'(s2_mag) - back;
    q    = (rem >= BACK_W'(ctrl.div_n)) ? s2_q0 + MAG_W'(1) : s2_q0;
    if (s2_big) begin
      q = Q_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s3_neg <= s2_neg;
      s3_q   <= q;
    end
  end

  always_comb begin
    scaled  = SCALE_W'(s3_q[Q_FRAC:0]) * SCALE_W'(PCM_SCALE);
    mag_out = ctrl.float_mode ? {1'b0, scaled[SCALE_W-1:Q_FRAC]} : s3_q[OUT_W:0];
    res     = s3_neg ? -mag_out : mag_out;
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      mono_sample <= $signed(res[OUT_W-1:0]);
    end
  end

endmodule

FILE: design/multichannel_to_mono_pcm16.sv
// ----------------------------------------------------------------------------
// multichannel_to_mono_pcm16
// Downmixes one frame of up to eight channel words to a signed 16-bit mono
// sample in float32, pcm16, pcm24 or pcm32 format.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_stall    silent, chan0 .. chan7
//  out       out_valid / out_stall  mono_sample
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One frame is accepted every cycle unless in_stall is high; each result
// passes through the registered stages in order (lane decode, two adder
// levels, abs/clamp, reciprocal multiply, correction, scaling). The decode
// lanes run in parallel, one per channel. Reset sets the format to pcm16
// and the channel count to one and empties the pipeline. A stalled output
// lets the stages behind it fill up before in_stall rises.
// ----------------------------------------------------------------------------
module multichannel_to_mono_pcm16
  import mcmono_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CH_DEF
)
(
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    silent,
  input  logic [31:0]             chan0,
  input  logic [31:0]             chan1,
  input  logic [31:0]             chan2,
  input  logic [31:0]             chan3,
  input  logic [31:0]             chan4,
  input  logic [31:0]             chan5,
  input  logic [31:0]             chan6,
  input  logic [31:0]             chan7,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] mono_sample,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int NSTG      = 7;
  localparam int ST_LANE   = 0;
  localparam int ST_MERGE  = 1;
  localparam int ST_SCALE  = 3;

  logic [FMT_W-1:0]         sample_format;
  logic [CNT_W-1:0]         channel_count;
  logic [CNT_W-1:0]         n_use;
  mcmono_div_ctrl_t         div_ctrl;
  logic                     fmt_ok;

  logic [NSTG-1:0]          vld;
  logic [NSTG-1:0]          load;

  logic [31:0]              words    [NUM_SLOTS];
  logic signed [LANE_W-1:0] lane_val [NUM_SLOTS];
  logic signed [SUM_W-1:0]  sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FORMAT_RST;
      channel_count <= COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FORMAT) begin
        sample_format <= cfg_data[FMT_W-1:0];
      end else if (cfg_index == REG_COUNT) begin
        channel_count <= cfg_data;
      end
    end
  end

  always_comb begin
    n_use = (channel_count > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                   : channel_count;
    fmt_ok              = (sample_format <= FMT_PCM32);
    div_ctrl.float_mode = (sample_format == FMT_FLOAT);
    // A zero count leaves every lane idle; dividing by one keeps the zero.
    div_ctrl.div_n      = (n_use == '0) ? CNT_W'(1) : n_use;
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    load[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (load[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_stall  = !load[ST_LANE];
  assign out_valid = vld[NSTG-1];

  assign words[0] = chan0;
  assign words[1] = chan1;
  assign words[2] = chan2;
  assign words[3] = chan3;
  assign words[4] = chan4;
  assign words[5] = chan5;
  assign words[6] = chan6;
  assign words[7] = chan7;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_lane
    if (i < MAX_CHANNELS) begin : g_used
      mcmono_lane_ctrl_t lane_ctrl;

      always_comb begin
        lane_ctrl.active = !silent && fmt_ok && (CNT_W'(i) < n_use);
        lane_ctrl.fmt    = sample_format;
      end

      mcmono_lane u_lane (
        .clk   (clk),
        .load  (load[ST_LANE]),
        .ctrl  (lane_ctrl),
        .word  (words[i]),
        .value (lane_val[i])
      );
    end else begin : g_unused
      assign lane_val[i] = '0;
    end
  end

  mcmono_merge u_merge (
    .clk      (clk),
    .load     (load[ST_MERGE+1:ST_MERGE]),
    .lane_val (lane_val),
    .sum      (sum)
  );

  mcmono_scale u_scale (
    .clk         (clk),
    .load        (load[ST_SCALE+3:ST_SCALE]),
    .ctrl        (div_ctrl),
    .sum         (sum),
    .mono_sample (mono_sample)
  );

  // Input is held back only when the output beat is blocked.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  // An accepted frame always lands in the lane stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[ST_LANE])
    else $error("accepted frame lost at lane stage");

  // Draining the last result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !vld[NSTG-2]) |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule

FILE: bench/tb_multichannel_to_mono_pcm16.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multichannel_to_mono_pcm16
// Self-checking bench for the downmix block. A short table of directed frames
// hits the format and count extremes, then random frames run under several
// register settings and three idle patterns. Every mono sample is compared
// in order against a bit-accurate prediction of the downmix.
// ----------------------------------------------------------------------------
module tb_multichannel_to_mono_pcm16;
  import mcmono_pkg::*;

  localparam int MAX_CH = MAX_CH_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 32;
  localparam int REPORT_MAX = 10;
  localparam int RAND_BLOCKS = 24;
  localparam int BLOCK_FRAMES = 48;

  localparam logic [FMT_W-1:0] FMT_NONE  = 3'd4;
  localparam logic [FMT_W-1:0] FMT_RSVD7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  localparam longint Q26_ONE = 64'sd1 << Q_FRAC;
  localparam longint MONO_SCALE = 64'sd32767;

  typedef struct packed {
    logic             silent;
    logic [7:0][31:0] ch;
  } frame_t;

  typedef struct packed {
    logic [3:0]         fmt;
    logic [3:0]         cnt;
    logic               silent;
    logic [7:0][31:0]   ch;
    logic               known;
    logic signed [15:0] want;
  } dir_row_t;

  // Channel words are listed from chan7 down to chan0.
  localparam dir_row_t DIR_ROWS [24] = '{
    '{{1'b0, FMT_PCM16}, 4'd1, 1'b0, {8{32'h0000_7FFF}}, 1'b1, 16'sd32767},
    '{{1'b0, FMT_PCM16}, 4'd1, 1'b0, {8{32'hFFFF_8000}}, 1'b1, 16'sh8000},
    '{{1'b0, FMT_PCM16}, 4'd8, 1'b0, {8{32'h0000_7FFF}}, 1'b1, 16'sd32767},
    '{{1'b0, FMT_PCM16}, 4'd8, 1'b0, {8{32'h1234_8000}}, 1'b1, 16'sh8000},
    '{{1'b0, FMT_PCM16}, 4'd3, 1'b0, {{7{32'h0}}, 32'h0000_FFFF}, 1'b1, 16'sd0},
    '{{1'b0, FMT_PCM16}, 4'd2, 1'b1, {8{32'h0000_7FFF}}, 1'b1, 16'sd0},
    '{{1'b0, FMT_PCM16}, 4'd15, 1'b0, {32'd8000, 32'd7000, 32'd6000, 32'd5000,
                               32'd4000, 32'd3000, 32'd2000, 32'd1000}, 1'b0, 16'sd0},
    '{{1'b0, FMT_PCM16}, 4'd0, 1'b0, {8{32'h0000_7FFF}}, 1'b1, 16'sd0},
    '{{1'b0, FMT_PCM24}, 4'd1, 1'b0, {8{32'h007F_FFFF}}, 1'b1, 16'sd32767},
    '{{1'b0, FMT_PCM24}, 4'd1, 1'b0, {8{32'hAB80_0000}}, 1'b1, 16'sh8000},
    '{{1'b0, FMT_PCM24}, 4'd1, 1'b0, {8{32'h00FF_FFFF}}, 1'b1, -16'sd1},
    '{{1'b0, FMT_PCM24}, 4'd5, 1'b0, {32'h0012_3456, 32'hFF80_0100, 32'h007F_FF00,
                              32'h0000_00FF, 32'h00FF_FF00, 32'h1234_5678,
                              32'h0040_0000, 32'h00C0_0000},
      1'b0, 16'sd0},
    '{{1'b0, FMT_PCM32}, 4'd1, 1'b0, {8{32'h7FFF_FFFF}}, 1'b1, 16'sd32767},
    '{{1'b0, FMT_PCM32}, 4'd1, 1'b0, {8{32'h8000_0000}}, 1'b1, 16'sh8000},
    '{{1'b0, FMT_PCM32}, 4'd8, 1'b0, {32'h7FFF_0000, 32'h8000_FFFF, 32'hFFFF_FFFF,
                              32'h0001_0000, 32'h4000_1234, 32'hC000_0000,
                              32'h1234_5678, 32'h0000_FFFF},
      1'b0, 16'sd0},
    '{{1'b0, FMT_FLOAT}, 4'd1, 1'b0, {8{32'h3F80_0000}}, 1'b1, 16'sd32767},
    '{{1'b0, FMT_FLOAT}, 4'd1, 1'b0, {8{32'hBF00_0000}}, 1'b1, -16'sd16383},
    '{{1'b0, FMT_FLOAT}, 4'd1, 1'b0, {8{32'hFF80_0000}}, 1'b1, -16'sd32767},
    '{{1'b0, FMT_FLOAT}, 4'd1, 1'b0, {8{32'h7FC0_0000}}, 1'b1, 16'sd0},
    '{{1'b0, FMT_FLOAT}, 4'd1, 1'b0, {8{32'h0000_0001}}, 1'b1, 16'sd0},
    '{{1'b0, FMT_FLOAT}, 4'd8, 1'b0, {32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                              32'h0000_0001, 32'h4000_0000, 32'hBE80_0000,
                              32'h3F80_0000, 32'h3EAA_AAAB},
      1'b0, 16'sd0},
    '{{1'b0, FMT_FLOAT}, 4'd8, 1'b1, {8{32'h3F80_0000}}, 1'b1, 16'sd0},
    // The format register keeps only its low three bits.
    '{{1'b1, FMT_NONE}, 4'd2, 1'b0, {8{32'h0000_7FFF}}, 1'b1, 16'sd0},
    '{{1'b0, FMT_RSVD7}, 4'd8, 1'b0, {8{32'h3F80_0000}}, 1'b1, 16'sd0}
  };

  localparam logic [3:0] FIXED_FMT [6] = '{{1'b0, FMT_FLOAT}, {1'b0, FMT_PCM16},
                                           {1'b0, FMT_PCM24}, {1'b0, FMT_PCM32},
                                           {1'b0, FMT_FLOAT}, {1'b0, FMT_PCM16}};
  localparam logic [3:0] FIXED_CNT [6] = '{4'd8, 4'd1, 4'd8, 4'd3, 4'd1, 4'd15};

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic silent = 1'b0;
  logic [31:0] chan0 = '0;
  logic [31:0] chan1 = '0;
  logic [31:0] chan2 = '0;
  logic [31:0] chan3 = '0;
  logic [31:0] chan4 = '0;
  logic [31:0] chan5 = '0;
  logic [31:0] chan6 = '0;
  logic [31:0] chan7 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] mono_sample;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [FMT_W-1:0] fmt_now = FORMAT_RST;
  logic [CNT_W-1:0] cnt_now = COUNT_RST;
  logic signed [15:0] mono_expected [$];
  logic signed [15:0] head_sample;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_cnt = 0;
  int frames_sent = 0;
  int samples_seen = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;

  multichannel_to_mono_pcm16 uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .silent(silent),
    .chan0(chan0), .chan1(chan1), .chan2(chan2), .chan3(chan3),
    .chan4(chan4), .chan5(chan5), .chan6(chan6), .chan7(chan7),
    .out_valid(out_valid), .out_stall(out_stall), .mono_sample(mono_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // IEEE single to Q5.26, truncating toward zero and saturating to 32 bits.
  function automatic longint float_to_q526(input logic [31:0] w);
    int ex;
    int sh;
    longint sig;
    longint mag;
    ex = int'(w[30:23]);
    if (ex == 255) begin
      if (w[22:0] != 0) return 0;
      mag = 64'hFFFF_FFFF;
    end else if (ex == 0) begin
      return 0;
    end else begin
      sig = longint'({1'b1, w[22:0]});
      sh = ex - 150 + Q_FRAC;
      if (sh > 8) mag = 64'hFFFF_FFFF;
      else if (sh >= 0) mag = sig << sh;
      else if (-sh >= 32) mag = 0;
      else mag = sig >> (-sh);
    end
    if (w[31]) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return -mag;
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag;
  endfunction

  function automatic logic signed [15:0] downmix_mono(input frame_t f,
                                                      input logic [FMT_W-1:0] fmt,
                                                      input logic [CNT_W-1:0] cnt);
    int n;
    longint qsum;
    longint qmean;
    int psum;
    logic signed [15:0] word16;
    n = (int'(cnt) > MAX_CH) ? MAX_CH : int'(cnt);
    if (f.silent || n == 0) return 16'sd0;
    case (fmt)
      FMT_FLOAT: begin
        qsum = 0;
        for (int c = 0; c < n; c++) qsum += float_to_q526(f.ch[c]);
        qmean = qsum / n;
        if (qmean > Q26_ONE) qmean = Q26_ONE;
        if (qmean < -Q26_ONE) qmean = -Q26_ONE;
        return 16'((qmean * MONO_SCALE) / Q26_ONE);
      end
      FMT_PCM16, FMT_PCM24, FMT_PCM32: begin
        psum = 0;
        for (int c = 0; c < n; c++) begin
          if (fmt == FMT_PCM16) word16 = f.ch[c][15:0];
          else if (fmt == FMT_PCM24) word16 = f.ch[c][23:8];
          else word16 = f.ch[c][31:16];
          psum += int'(word16);
        end
        return 16'(psum / n);
      end
      default: return 16'sd0;
    endcase
  endfunction

  // Mostly values near full scale, with saturating, infinite, NaN and
  // subnormal words mixed in.
  function automatic logic [31:0] rand_float_word();
    logic [31:0] r;
    logic [7:0] ex;
    int kind;
    r = $urandom();
    kind = $urandom_range(0, 15);
    ex = r[30:23];
    case (kind)
      0, 1, 2, 3, 4, 5, 6, 7, 8: ex = 8'($urandom_range(116, 127));
      9:  ex = 8'($urandom_range(1, 254));
      10: ex = 8'd0;
      11: begin
        ex = 8'hFF;
        r[22:0] = '0;
      end
      12: begin
        ex = 8'hFF;
        r[0] = 1'b1;
      end
      13: ex = 8'($urandom_range(128, 135));
      default: ;
    endcase
    r[30:23] = ex;
    return r;
  endfunction

  function automatic logic [31:0] rand_pcm_word(input logic [FMT_W-1:0] fmt);
    logic [31:0] w;
    int lsb;
    int kind;
    w = $urandom();
    kind = $urandom_range(0, 7);
    lsb = (fmt == FMT_PCM24) ? 8 : (fmt == FMT_PCM32) ? 16 : 0;
    if (kind == 0) w[lsb +: 16] = 16'h7FFF;
    else if (kind == 1) w[lsb +: 16] = 16'h8000;
    else if (kind == 2) w[lsb +: 16] = 16'($urandom_range(0, 3)) - 16'd2;
    return w;
  endfunction

  function automatic frame_t rand_frame(input logic [FMT_W-1:0] fmt);
    frame_t f;
    f.silent = ($urandom_range(0, 9) == 0);
    for (int c = 0; c < 8; c++)
      f.ch[c] = (fmt == FMT_FLOAT) ? rand_float_word() : rand_pcm_word(fmt);
    return f;
  endfunction

  task automatic send_frame(input frame_t f, input logic known,
                            input logic signed [15:0] want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    silent <= f.silent;
    chan0 <= f.ch[0];
    chan1 <= f.ch[1];
    chan2 <= f.ch[2];
    chan3 <= f.ch[3];
    chan4 <= f.ch[4];
    chan5 <= f.ch[5];
    chan6 <= f.ch[6];
    chan7 <= f.ch[7];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mono_expected.insert(mono_expected.size(),
                         known ? want : downmix_mono(f, fmt_now, cnt_now));
    frames_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (mono_expected.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need one assignment per edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FORMAT: fmt_now = data[FMT_W-1:0];
      REG_COUNT:  cnt_now = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_mode(input logic [3:0] fmt_data, input logic [3:0] cnt_data,
                          input logic poke_spare);
    write_reg(REG_FORMAT, fmt_data);
    write_reg(REG_COUNT, cnt_data);
    if (poke_spare)
      write_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3, 4'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (mono_expected.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
          $display("sample %0d arrived with nothing pending", mono_sample);
      end else begin
        head_sample = mono_expected.pop_front();
        if (mono_sample !== head_sample) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("mismatch on sample %0d: expected %0d, got %0d",
                     samples_seen, head_sample, mono_sample);
        end
        samples_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no beat moved for %0d cycles", IDLE_LIMIT);
        $display("tb_multichannel_to_mono_pcm16: FAIL");
        $finish;
      end
    end
  end

  initial begin
    frame_t f;
    dir_row_t row;
    logic [3:0] fmt_data;
    logic [3:0] cnt_data;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 48;
    for (int i = 0; i < 24; i++) begin
      row = DIR_ROWS[i];
      if (row.fmt[FMT_W-1:0] != fmt_now || row.cnt != cnt_now) begin
        wait_drained();
        set_mode(row.fmt, row.cnt, i == 11);
      end
      f.silent = row.silent;
      f.ch = row.ch;
      send_frame(f, row.known, row.want);
    end

    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      case (blk / 8)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (blk < 6) begin
        fmt_data = FIXED_FMT[blk];
        cnt_data = FIXED_CNT[blk];
      end else begin
        fmt_data = 4'($urandom_range(0, 15));
        // Keep the unsupported formats to a small share of the blocks.
        if (fmt_data[2] && $urandom_range(0, 2) != 0) fmt_data[2] = 1'b0;
        if ($urandom_range(0, 9) == 0) cnt_data = 4'($urandom_range(0, 15));
        else cnt_data = 4'($urandom_range(1, MAX_CH));
      end
      wait_drained();
      set_mode(fmt_data, cnt_data, blk % 5 == 2);
      for (int k = 0; k < BLOCK_FRAMES; k++) begin
        if (blk == 4 && k == BLOCK_FRAMES / 2) wait_drained();
        send_frame(rand_frame(fmt_now), 1'b0, 16'sd0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d frames sent, %0d mono samples checked, %0d register writes",
             frames_sent, samples_seen, cfg_writes);
    $display("covered all four formats, unsupported codes, counts from zero past eight");
    if (fail_cnt == 0) begin
      $display("tb_multichannel_to_mono_pcm16: PASS");
    end else begin
      $display("%0d failing samples", fail_cnt);
      $display("tb_multichannel_to_mono_pcm16: FAIL");
    end
    $finish;
  end

endmodule
